>>> design/fsn_pkg.sv
// Package for the flow shop scheduler: sizes, types and controller codes.
package fsn_pkg;
	localparam int MaxJobs = 32;
	localparam int MaxMachines = 20;
	localparam int JobW = $clog2(MaxJobs);
	localparam int MachW = $clog2(MaxMachines);
	localparam int StoreDepth = MaxJobs * MaxMachines;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int PosW = AddrW + 1;
	localparam int TimeW = 10;
	localparam int TotW = 15;
	localparam int SpanW = 16;
	localparam int JcW = 6;
	localparam int McW = 5;
	localparam int CntW = JobW + 1;

	localparam logic [0:0] RegJobCount = 1'd0;
	localparam logic [0:0] RegMachCount = 1'd1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_TOT_RD,
		ST_TOT_ACC,
		ST_SORT,
		ST_SORT_CMP,
		ST_TRY_INIT,
		ST_TRY_RD,
		ST_TRY_ACC,
		ST_TRY_DONE,
		ST_INSERT,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic store_wr;
		logic clr_tot;
		logic tot_acc;
		logic tot_wr;
		logic row_clr;
		logic row_step;
		logic trial_best;
		logic ins_shift;
		logic ins_place;
		logic sort_shift;
		logic sort_place;
		logic [JobW-1:0] job;
		logic [MachW-1:0] mach;
		logic [CntW-1:0] pos;
		logic [CntW-1:0] k;
		logic [CntW-1:0] tpos;
		logic [CntW-1:0] slot;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sort_less;
		logic best_better;
		logic [CntW-1:0] best_pos;
	} stat_t;

	function automatic logic [SpanW-1:0] sat_add(input logic [SpanW-1:0] a,
			input logic [TimeW-1:0] b);
		logic [SpanW:0] s;
		s = {1'b0, a} + {{(SpanW+1-TimeW){1'b0}}, b};
		sat_add = s[SpanW] ? {SpanW{1'b1}} : s[SpanW-1:0];
	endfunction
endpackage

>>> design/fsn_ram.sv
// Generic simple dual port RAM (one write port, one read port) with registered read.
module fsn_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/fsn_datapath.sv
// Datapath: time store, totals, sort and sequence arrays, completion row.
module fsn_datapath (
	input  logic                       clk,
	input  fsn_pkg::cmd_t              cmd,
	input  logic [fsn_pkg::TimeW-1:0]  wr_time,
	input  logic [fsn_pkg::AddrW-1:0]  wr_addr,
	input  logic [fsn_pkg::AddrW-1:0]  rd_addr,
	input  logic                       rd_zero,
	input  logic [fsn_pkg::MachW-1:0]  mach_last,
	output fsn_pkg::stat_t             stat,
	output logic [fsn_pkg::JobW-1:0]   out_job,
	output logic [fsn_pkg::SpanW-1:0]  out_span
);
	import fsn_pkg::*;

	logic [TimeW-1:0] rdata;
	logic             zero_s1;
	logic [TimeW-1:0] t_eff;
	logic [TotW-1:0]  tot_acc_q;
	logic [TotW-1:0]  totals_q [MaxJobs];
	logic [JobW-1:0]  sorted_q [MaxJobs];
	logic [JobW-1:0]  seq_q [MaxJobs];
	logic [SpanW-1:0] row_q [MaxMachines];
	logic [SpanW-1:0] best_q;
	logic [CntW-1:0]  bestp_q;
	logic [SpanW-1:0] base;
	logic [SpanW-1:0] span_now;

	fsn_ram #(.Width(TimeW), .Depth(StoreDepth)) u_store (
		.clk(clk), .we(cmd.store_wr), .waddr(wr_addr), .wdata(wr_time),
		.raddr(rd_addr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		zero_s1 <= rd_zero;
	end
	assign t_eff = zero_s1 ? '0 : rdata;

	// totals accumulate, stored without reset
	always_ff @(posedge clk) begin
		if (cmd.clr_tot) begin
			tot_acc_q <= '0;
		end else if (cmd.tot_acc) begin
			tot_acc_q <= tot_acc_q + {{(TotW-TimeW){1'b0}}, t_eff};
		end
		if (cmd.tot_wr) begin
			totals_q[cmd.job] <= tot_acc_q + {{(TotW-TimeW){1'b0}}, t_eff};
		end
	end

	// stable insertion sort: slot walks down while predecessor total is smaller
	assign stat.sort_less = totals_q[sorted_q[cmd.slot[JobW-1:0] - 1'b1]] <
		totals_q[cmd.job];

	always_ff @(posedge clk) begin
		if (cmd.sort_shift) begin
			sorted_q[cmd.slot[JobW-1:0]] <= sorted_q[cmd.slot[JobW-1:0] - 1'b1];
		end else if (cmd.sort_place) begin
			sorted_q[cmd.slot[JobW-1:0]] <= cmd.job;
		end
	end

	// completion row recurrence, one machine per row step
	assign base = (cmd.mach != '0 && row_q[cmd.mach - 1'b1] > row_q[cmd.mach]) ?
		row_q[cmd.mach - 1'b1] : row_q[cmd.mach];

	always_ff @(posedge clk) begin
		if (cmd.row_clr) begin
			for (int m = 0; m < MaxMachines; m++) row_q[m] <= '0;
		end else if (cmd.row_step) begin
			row_q[cmd.mach] <= sat_add(base, t_eff);
		end
	end

	assign span_now = row_q[mach_last];
	assign stat.best_better = (cmd.tpos == '0) || (span_now < best_q);
	assign stat.best_pos = bestp_q;

	always_ff @(posedge clk) begin
		if (cmd.trial_best && stat.best_better) begin
			best_q <= span_now;
			bestp_q <= cmd.tpos;
		end
	end

	// sequence store: shift up one slot a cycle then place
	always_ff @(posedge clk) begin
		if (cmd.ins_shift) begin
			seq_q[cmd.slot[JobW-1:0]] <= seq_q[cmd.slot[JobW-1:0] - 1'b1];
		end else if (cmd.ins_place) begin
			seq_q[cmd.slot[JobW-1:0]] <= sorted_q[cmd.k[JobW-1:0]];
		end
	end

	// job at trial position pos of sequence with candidate inserted at tpos
	always_comb begin
		if (cmd.pos < cmd.tpos) begin
			out_job = seq_q[cmd.pos[JobW-1:0]];
		end else if (cmd.pos == cmd.tpos) begin
			out_job = sorted_q[cmd.k[JobW-1:0]];
		end else begin
			out_job = seq_q[cmd.pos[JobW-1:0] - 1'b1];
		end
	end
	assign out_span = span_now;
endmodule

>>> design/fsn_ctrl.sv
// Controller: load, totals, sort, insertion trials and emit sequencing.
module fsn_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_last,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_last,
	input  logic [fsn_pkg::JcW-1:0]   jc_raw,
	input  logic [fsn_pkg::McW-1:0]   mc_raw,
	input  fsn_pkg::stat_t            stat,
	input  logic [fsn_pkg::JobW-1:0]  trial_job,
	output fsn_pkg::cmd_t             cmd,
	output logic [fsn_pkg::AddrW-1:0] wr_addr,
	output logic [fsn_pkg::AddrW-1:0] rd_addr,
	output logic                      rd_zero,
	output logic [fsn_pkg::MachW-1:0] mach_last
);
	import fsn_pkg::*;

	state_t state_q, state_d;
	logic [PosW-1:0] load_q, load_d;
	logic [CntW-1:0] i_q, i_d, k_q, k_d, p_q, p_d, t_q, t_d, s_q, s_d;
	logic [MachW-1:0] m_q, m_d;
	logic [CntW-1:0] n;
	logic [MachW:0]  mc;
	logic [PosW-1:0] full;
	logic [JobW-1:0] rjob;
	logic [PosW-1:0] idx;

	// clamp registers
	always_comb begin
		if (jc_raw == '0) n = CntW'(1);
		else if (jc_raw > JcW'(MaxJobs)) n = CntW'(MaxJobs);
		else n = CntW'(jc_raw);
		if (mc_raw == '0) mc = (MachW+1)'(1);
		else if (mc_raw > McW'(MaxMachines)) mc = (MachW+1)'(MaxMachines);
		else mc = (MachW+1)'(mc_raw);
	end
	assign mach_last = MachW'(mc - 1'b1);
	assign full = PosW'(n) * PosW'(mc);
	assign wr_addr = load_q[AddrW-1:0];

	// read address: job under consideration times machines plus machine
	assign rjob = (state_q == ST_TOT_RD) ? i_q[JobW-1:0] : trial_job;
	assign idx = PosW'(rjob) * PosW'(mc) + PosW'(m_q);
	assign rd_addr = idx[AddrW-1:0];
	assign rd_zero = idx >= load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q <= '0;
			i_q <= '0; k_q <= '0; p_q <= '0; t_q <= '0; s_q <= '0; m_q <= '0;
		end else begin
			state_q <= state_d;
			load_q <= load_d;
			i_q <= i_d; k_q <= k_d; p_q <= p_d; t_q <= t_d; s_q <= s_d; m_q <= m_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load_d = load_q;
		i_d = i_q; k_d = k_q; p_d = p_q; t_d = t_q; s_d = s_q; m_d = m_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_last = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (load_q < full) begin
						cmd.store_wr = 1'b1;
						load_d = load_q + 1'b1;
					end
					if (in_last) begin
						state_d = ST_TOT_RD;
						i_d = '0; m_d = '0;
					end
				end
			end
			// one read per machine; the data lands next cycle, in ST_TOT_ACC
			ST_TOT_RD: begin
				if (m_q == '0) cmd.clr_tot = 1'b1;
				state_d = ST_TOT_ACC;
			end
			ST_TOT_ACC: begin
				cmd.job = i_q[JobW-1:0];
				if (m_q == mach_last) begin
					cmd.tot_wr = 1'b1;
					m_d = '0;
					if (i_q + 1'b1 == n) begin
						state_d = ST_SORT;
						i_d = '0; s_d = '0;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_TOT_RD;
					end
				end else begin
					cmd.tot_acc = 1'b1;
					m_d = m_q + 1'b1;
					state_d = ST_TOT_RD;
				end
			end
			ST_SORT: begin
				s_d = i_q;
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				cmd.job = i_q[JobW-1:0];
				cmd.slot = s_q;
				if (s_q != '0 && stat.sort_less) begin
					cmd.sort_shift = 1'b1;
					s_d = s_q - 1'b1;
				end else begin
					cmd.sort_place = 1'b1;
					if (i_q + 1'b1 == n) begin
						// seed sequence with first sorted job by a direct insert at k=0
						k_d = '0; t_d = '0;
						state_d = ST_INSERT;
						s_d = '0;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_SORT;
					end
				end
			end
			ST_TRY_INIT: begin
				cmd.row_clr = 1'b1;
				p_d = '0; m_d = '0;
				state_d = ST_TRY_RD;
			end
			ST_TRY_RD: begin
				cmd.pos = p_q; cmd.tpos = t_q; cmd.k = k_q;
				state_d = ST_TRY_ACC;
			end
			ST_TRY_ACC: begin
				cmd.pos = p_q; cmd.tpos = t_q; cmd.k = k_q;
				cmd.mach = m_q;
				cmd.row_step = 1'b1;
				state_d = ST_TRY_RD;
				if (m_q == mach_last) begin
					m_d = '0;
					if (p_q == k_q) state_d = ST_TRY_DONE;
					else p_d = p_q + 1'b1;
				end else begin
					m_d = m_q + 1'b1;
				end
			end
			ST_TRY_DONE: begin
				cmd.tpos = t_q; cmd.k = k_q;
				if (k_q == n) begin
					state_d = ST_EMIT;
					i_d = '0;
				end else begin
					cmd.trial_best = 1'b1;
					if (t_q == k_q) begin
						state_d = ST_INSERT;
						s_d = k_q;
					end else begin
						t_d = t_q + 1'b1;
						state_d = ST_TRY_INIT;
					end
				end
			end
			// shift sequence up to best position, then place candidate
			ST_INSERT: begin
				cmd.k = k_q;
				cmd.slot = s_q;
				if (s_q > stat.best_pos && k_q != '0) begin
					cmd.ins_shift = 1'b1;
					s_d = s_q - 1'b1;
				end else begin
					cmd.ins_place = 1'b1;
					t_d = '0;
					k_d = k_q + 1'b1;
					state_d = ST_TRY_INIT;
				end
			end
			ST_EMIT: begin
				cmd.pos = i_q;
				cmd.tpos = {CntW{1'b1}};
				out_valid = 1'b1;
				out_last = (i_q + 1'b1 == n);
				if (out_ready) begin
					if (out_last) begin
						state_d = ST_LOAD;
						load_d = '0;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
		// the final pass with k equal to n schedules the whole sequence
		if (state_q == ST_TRY_INIT || state_q == ST_TRY_RD || state_q == ST_TRY_ACC) begin
			if (k_q == n) cmd.tpos = {CntW{1'b1}};
		end
		if (state_q == ST_TRY_ACC && k_q == n && m_q == mach_last && p_q == k_q - 1'b1) begin
			state_d = ST_TRY_DONE;
		end
	end
endmodule

>>> design/flow_shop_neh_scheduler.sv
// Top level of the NEH permutation flow shop scheduler.
// Usage:
//  Write job_count (index 0) and machine_count (index 1) on the cfg channel
//  while idle. Stream processing times on s_axis, one word per cycle, in
//  job-major order; tlast on the final word starts scheduling. Surplus
//  words are dropped. While scheduling, s_axis_tready is low.
//  Results leave on m_axis: one word per job in final sequence order, with
//  tlast and the makespan on the final word (makespan zero elsewhere).
//  The insertion trials run on the single completion row unit, which walks
//  the machines one at a time, each with a RAM read then an update.
//  Output words hold while m_axis_tready is low; loading resumes after the
//  final word is taken. Reset returns to loading with an empty store and
//  both registers at one.
module flow_shop_neh_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // proc_time[9:0]
	input  logic        s_axis_tlast,  // last_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // job_number[4:0], makespan[20:5]
	output logic        m_axis_tlast   // last_job
);
	import fsn_pkg::*;

	logic [JcW-1:0] jc_q;
	logic [McW-1:0] mc_q;
	cmd_t  cmd;
	stat_t stat;
	logic [AddrW-1:0] wr_addr, rd_addr;
	logic rd_zero;
	logic [MachW-1:0] mach_last;
	logic [JobW-1:0] job;
	logic [SpanW-1:0] span;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jc_q <= JcW'(1);
			mc_q <= McW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				RegJobCount: jc_q <= cfg_data;
				RegMachCount: mc_q <= cfg_data[McW-1:0];
				default: ;
			endcase
		end
	end

	fsn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_last(m_axis_tlast),
		.jc_raw(jc_q), .mc_raw(mc_q), .stat(stat), .trial_job(job), .cmd(cmd),
		.wr_addr(wr_addr), .rd_addr(rd_addr), .rd_zero(rd_zero), .mach_last(mach_last)
	);

	fsn_datapath u_dp (
		.clk(clk), .cmd(cmd), .wr_time(s_axis_tdata[TimeW-1:0]),
		.wr_addr(wr_addr), .rd_addr(rd_addr), .rd_zero(rd_zero),
		.mach_last(mach_last), .stat(stat), .out_job(job), .out_span(span)
	);

	assign m_axis_tdata = {3'b000, (m_axis_tlast ? span : {SpanW{1'b0}}), job};
endmodule

>>> bench/flow_shop_neh_scheduler_tb.sv
// Self-checking bench for the NEH flow shop scheduler: scoreboard, stimulus and stalls.
module flow_shop_neh_scheduler_tb;
	import fsn_pkg::*;

	localparam int CycleLimit = 4000000;

	typedef struct {
		logic [JobW-1:0]  job;
		logic [SpanW-1:0] span;
		logic             last;
	} seq_word_t;

	// Scoreboard: own copy of the loaded instance and registers, NEH predictor
	class neh_scoreboard;
		logic [TimeW-1:0] times [StoreDepth];
		int unsigned fill;
		int unsigned jobs_reg;
		int unsigned mach_reg;
		seq_word_t   sched_q[$];
		int          errors;
		int          words_seen;

		function new();
			fill = 0;
			jobs_reg = 1;
			mach_reg = 1;
			errors = 0;
			words_seen = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [5:0] val);
			if (idx == RegJobCount) jobs_reg = val;
			else mach_reg = val & 31;
		endfunction

		function int unsigned eff_jobs();
			if (jobs_reg < 1) return 1;
			if (jobs_reg > MaxJobs) return MaxJobs;
			return jobs_reg;
		endfunction

		function int unsigned eff_machs();
			if (mach_reg < 1) return 1;
			if (mach_reg > MaxMachines) return MaxMachines;
			return mach_reg;
		endfunction

		// times beyond the loaded part read as zero
		function int unsigned fetch(int unsigned job, int unsigned mach, int unsigned mc);
			int unsigned idx;
			idx = job * mc + mach;
			if (idx >= fill) return 0;
			return times[idx];
		endfunction

		function int unsigned makespan(int unsigned ord[MaxJobs], int unsigned len,
				int unsigned mc);
			int unsigned row [MaxMachines];
			int unsigned acc;
			for (int m = 0; m < mc; m++) row[m] = 0;
			for (int j = 0; j < len; j++) begin
				for (int m = 0; m < mc; m++) begin
					acc = row[m];
					if (m > 0 && row[m-1] > acc) acc = row[m-1];
					acc += fetch(ord[j], m, mc);
					row[m] = (acc > 65535) ? 65535 : acc;
				end
			end
			return row[mc-1];
		endfunction

		// one accepted time word; tlast runs the heuristic
		function void note_word(logic [TimeW-1:0] ptime, logic tl);
			int unsigned n, mc, s, j, best, bestp, sp, t;
			int unsigned tot [MaxJobs];
			int unsigned order [MaxJobs];
			int unsigned seq [MaxJobs];
			int unsigned trial [MaxJobs];
			seq_word_t w;
			n = eff_jobs();
			mc = eff_machs();
			if (fill < n * mc) begin
				times[fill] = ptime;
				fill++;
			end
			if (!tl) return;
			for (int i = 0; i < n; i++) begin
				s = 0;
				for (int m = 0; m < mc; m++) s += fetch(i, m, mc);
				tot[i] = s & 32'h7fff;
			end
			// stable sort, largest total first
			for (int i = 0; i < n; i++) begin
				j = i;
				while (j > 0 && tot[order[j-1]] < tot[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = i;
			end
			seq[0] = order[0];
			for (int k = 1; k < n; k++) begin
				best = 32'hffffffff;
				bestp = 0;
				for (int p = 0; p <= k; p++) begin
					t = 0;
					for (int q = 0; q < p; q++) begin
						trial[t] = seq[q];
						t++;
					end
					trial[t] = order[k];
					t++;
					for (int q = p; q < k; q++) begin
						trial[t] = seq[q];
						t++;
					end
					sp = makespan(trial, k + 1, mc);
					if (sp < best) begin
						best = sp;
						bestp = p;
					end
				end
				for (int p = k; p > bestp; p--) seq[p] = seq[p-1];
				seq[bestp] = order[k];
			end
			sp = makespan(seq, n, mc);
			for (int i = 0; i < n; i++) begin
				w.job = JobW'(seq[i]);
				w.last = (i + 1 == n);
				w.span = w.last ? sp[SpanW-1:0] : '0;
				sched_q.push_back(w);
			end
			fill = 0;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_word(logic [JobW-1:0] job, logic [SpanW-1:0] span, logic tl);
			seq_word_t e;
			words_seen++;
			if (sched_q.size() == 0) begin
				report($sformatf("unexpected word job %0d span %0d last %0b", job, span, tl));
				return;
			end
			e = sched_q.pop_front();
			if (job !== e.job)
				report($sformatf("job_number %0d, want %0d", job, e.job));
			if (span !== e.span)
				report($sformatf("makespan %0d, want %0d", span, e.span));
			if (tl !== e.last)
				report($sformatf("last_job %0b, want %0b", tl, e.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [5:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	neh_scoreboard sb = new();
	int unsigned   cycles = 0;
	int unsigned   items_sent = 0;
	int            burst_left = 0;
	bit            bursty = 1'b1;
	bit            hold_done = 1'b0;

	flow_shop_neh_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: check on rising edge, set tready on falling edge
	initial begin : receiver
		int hold_left;
		int mode;
		int phase_cnt;
		hold_left = 0;
		mode = 0;
		phase_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tlast);
			// long hold while the sender is still offering words
			if (!hold_done && m_axis_tvalid && s_axis_tvalid && sb.words_seen >= 100) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			@(negedge clk);
			if (phase_cnt == 0) begin
				mode = $urandom_range(0, 2);
				phase_cnt = $urandom_range(16, 96);
			end
			phase_cnt--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					default: m_axis_tready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic write_cfg(logic [0:0] idx, logic [5:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_time(logic [TimeW-1:0] ptime, logic tl);
		int gap;
		if (bursty && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'b0, ptime};
		s_axis_tlast = tl;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(ptime, tl);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.sched_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one instance of cnt words; kind 0 random, 1 low values (ties), 2 all equal
	task automatic send_instance(int cnt, int kind);
		logic [TimeW-1:0] v;
		for (int i = 0; i < cnt; i++) begin
			case (kind)
				0: v = $urandom_range(0, 1023);
				1: v = $urandom_range(0, 3);
				default: v = 10'd7;
			endcase
			send_time(v, i == cnt - 1);
		end
	endtask

	initial begin : stimulus
		int j;
		int m;
		int sel;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset: single job, single machine
		send_time(10'd0, 1'b1);
		send_time(10'd1023, 1'b1);
		drain();
		// zero register values act as one
		write_cfg(RegJobCount, 6'd0);
		write_cfg(RegMachCount, 6'd0);
		send_time(10'd5, 1'b1);
		drain();
		// ties, short instance, surplus times
		write_cfg(RegJobCount, 6'd3);
		write_cfg(RegMachCount, 6'd2);
		send_instance(6, 2);
		send_instance(3, 0);
		send_instance(8, 0);
		drain();
		// register change part way through loading
		write_cfg(RegJobCount, 6'd2);
		write_cfg(RegMachCount, 6'd2);
		send_time(10'd100, 1'b0);
		send_time(10'd3, 1'b0);
		send_time(10'd1023, 1'b0);
		drain();
		write_cfg(RegMachCount, 6'd3);
		send_time(10'd512, 1'b1);
		drain();
		// above the maximum: 32 jobs on one machine, then 2 jobs on 20 machines
		write_cfg(RegJobCount, 6'd63);
		write_cfg(RegMachCount, 6'd1);
		send_instance(32, 0);
		drain();
		write_cfg(RegJobCount, 6'd2);
		write_cfg(RegMachCount, 6'd31);
		send_instance(40, 0);
		drain();
		// largest instance, loaded short to keep load time down
		write_cfg(RegJobCount, 6'd32);
		write_cfg(RegMachCount, 6'd20);
		send_instance(25, 0);
		drain();

		// random phases of small instances
		while (items_sent < 240) begin
			j = $urandom_range(1, 6);
			m = $urandom_range(1, 6);
			write_cfg(RegJobCount, 6'(j));
			write_cfg(RegMachCount, 6'(m));
			bursty = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(2, 4)) begin
				sel = $urandom_range(0, 19);
				if (sel < 14) send_instance(j * m, sel < 3 ? 1 : 0);
				else if (sel < 17) send_instance($urandom_range(1, j * m), 0);
				else send_instance(j * m + $urandom_range(1, 4), 0);
			end
			drain();
		end
		// another maximal job count on one machine to exercise the limit again
		write_cfg(RegJobCount, 6'd32);
		write_cfg(RegMachCount, 6'd1);
		send_instance(32, 1);
		drain();
		repeat (50) @(posedge clk);

		if (sb.sched_q.size() > 0)
			sb.report($sformatf("%0d words never arrived", sb.sched_q.size()));
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
